[hdl/bf5_pkg.sv]
// Shared constants for the 5x5 box filter block.
`default_nettype none

package bf5_pkg;

  localparam int PIXEL_W   = 8;
  localparam int PIXEL_MAX = 255;
  localparam int POS_W     = 3;

endpackage : bf5_pkg

`default_nettype wire

[hdl/bf5_if.sv]
// Valid/ready channel interfaces for the pixel input and the result output.
`default_nettype none

interface bf5_pixel_if;
  import bf5_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface : bf5_pixel_if

interface bf5_result_if;
  import bf5_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] smoothed;
  logic [POS_W-1:0]   out_row;
  logic [POS_W-1:0]   out_col;
  logic               run_last;
  logic               frame_end;

  modport source (
    output valid, output smoothed, output out_row, output out_col,
    output run_last, output frame_end, input ready
  );
  modport sink (
    input valid, input smoothed, input out_row, input out_col,
    input run_last, input frame_end, output ready
  );
endinterface : bf5_result_if

`default_nettype wire

[hdl/bf5_line_store.sv]
// Circular line store: one write port and one read port with registered read data.
`default_nettype none

module bf5_line_store #(
  parameter int DEPTH = 40
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic [bf5_pkg::PIXEL_W-1:0]  wdata,
  input  logic                         re,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output logic [bf5_pkg::PIXEL_W-1:0]  rdata
);
  import bf5_pkg::*;

  logic [PIXEL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : bf5_line_store

`default_nettype wire

[hdl/box_filter_5x5_zero_pad.sv]
// Top level of the box filter: mean over a square window with zero padding.
//
// Pixels of an IMAGE_SIZE x IMAGE_SIZE frame enter in raster order, and every
// result is the window sum divided by WINDOW*WINDOW, truncated. The last
// WINDOW rows are kept in a single-port-read line store. A pixel is taken in
// ST_IDLE and checked in the next cycle, in ST_CHECK. Each result fetches one
// column sum of the window from the line store, one read per window row
// inside the frame; the first result of each row first loads (WINDOW-1)/2
// more columns. The last pixel of a frame releases all results still
// pending, and the counters then restart for the next frame. The output
// register lets the next pixel be taken while a result waits to be taken.
`default_nettype none

module box_filter_5x5_zero_pad #(
  parameter int IMAGE_SIZE = 8,
  parameter int WINDOW     = 5
) (
  input  logic                clk,
  input  logic                rst,
  bf5_pixel_if.sink           pixels,
  bf5_result_if.source        results
);
  import bf5_pkg::*;

  localparam int HALF_UP    = WINDOW / 2;
  localparam int HALF_DOWN  = WINDOW - 1 - HALF_UP;
  localparam int AREA       = WINDOW * WINDOW;
  localparam int DEPTH      = WINDOW * IMAGE_SIZE;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int SLOT_W     = $clog2(WINDOW);
  localparam int ROW_W      = $clog2(IMAGE_SIZE);
  localparam int ER_W       = $clog2(IMAGE_SIZE + 1);
  localparam int CMP_W      = $clog2(IMAGE_SIZE + WINDOW + 1);
  localparam int K_W        = $clog2(WINDOW + 1);
  localparam int COL_SUM_W  = $clog2(WINDOW * PIXEL_MAX + 1);
  localparam int SUM_W      = $clog2(AREA * PIXEL_MAX + 1);
  localparam int DIV_SH     = SUM_W + $clog2(AREA);
  localparam int RECIP      = ((1 << DIV_SH) + AREA - 1) / AREA;
  localparam int PROD_W     = DIV_SH + PIXEL_W;
  localparam int BASE_RESET = WINDOW - HALF_UP;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_COLUMN,
    ST_SHIFT,
    ST_MUL,
    ST_EMIT
  } state_t;

  state_t                 state;
  logic [ROW_W-1:0]       in_row;
  logic [ROW_W-1:0]       in_col;
  logic [SLOT_W-1:0]      in_slot;
  logic [ROW_W-1:0]       cur_r;
  logic [ROW_W-1:0]       cur_c;
  logic                   cur_last;
  logic [ER_W-1:0]        emit_row;
  logic [ROW_W-1:0]       emit_col;
  logic [SLOT_W-1:0]      base_slot;
  logic [CMP_W-1:0]       fetch_col;
  logic [K_W-1:0]         pre_cnt;
  logic [K_W-1:0]         rd_k;
  logic [SLOT_W-1:0]      rd_slot;
  logic [CMP_W-1:0]       rd_off;
  logic                   rd_vq;
  logic [COL_SUM_W-1:0]   col_acc;
  logic [COL_SUM_W-1:0]   taps [WINDOW];
  logic [SUM_W-1:0]       win_sum;
  logic [PROD_W-1:0]      prod;

  logic                   res_valid;
  logic [PIXEL_W-1:0]     res_smoothed;
  logic [POS_W-1:0]       res_row;
  logic [POS_W-1:0]       res_col;
  logic                   res_run_last;
  logic                   res_frame_end;

  logic                   accept;
  logic                   in_is_last;
  logic                   out_free;
  logic                   fetch_en;
  logic [ADDR_W-1:0]      waddr;
  logic [ADDR_W-1:0]      raddr;
  logic [PIXEL_W-1:0]     rdata;
  logic [COL_SUM_W-1:0]   col_total;
  logic                   col_wrap;
  logic [ROW_W-1:0]       nx_col;
  logic [ER_W-1:0]        nx_row;
  logic                   cond_now;
  logic                   cond_next;
  logic [SLOT_W-1:0]      base_slot_inc;
  logic [SLOT_W-1:0]      rd_slot_inc;

  function automatic logic can_emit(
    input logic [ER_W-1:0]  er,
    input logic [ROW_W-1:0] ec,
    input logic [ROW_W-1:0] r,
    input logic [ROW_W-1:0] c,
    input logic             last
  );
    logic [CMP_W-1:0] nr;
    logic [CMP_W-1:0] nc;
    nr = CMP_W'(er) + CMP_W'(HALF_DOWN);
    nc = CMP_W'(ec) + CMP_W'(HALF_DOWN);
    if (nr > CMP_W'(IMAGE_SIZE - 1)) begin
      nr = CMP_W'(IMAGE_SIZE - 1);
    end
    if (nc > CMP_W'(IMAGE_SIZE - 1)) begin
      nc = CMP_W'(IMAGE_SIZE - 1);
    end
    return (er < ER_W'(IMAGE_SIZE)) &&
           (last || (nr < CMP_W'(r)) || ((nr == CMP_W'(r)) && (nc <= CMP_W'(c))));
  endfunction

  assign accept     = pixels.valid && pixels.ready;
  assign in_is_last = (in_row == ROW_W'(IMAGE_SIZE - 1)) && (in_col == ROW_W'(IMAGE_SIZE - 1));
  assign out_free   = !res_valid || results.ready;

  assign fetch_en = (state == ST_COLUMN) &&
                    (rd_off >= CMP_W'(HALF_UP)) &&
                    (rd_off < CMP_W'(IMAGE_SIZE + HALF_UP)) &&
                    (fetch_col < CMP_W'(IMAGE_SIZE));

  assign waddr = ADDR_W'(ADDR_W'(in_slot) * ADDR_W'(IMAGE_SIZE)) + ADDR_W'(in_col);
  assign raddr = ADDR_W'(ADDR_W'(rd_slot) * ADDR_W'(IMAGE_SIZE)) + ADDR_W'(fetch_col);

  assign col_total = col_acc + (rd_vq ? COL_SUM_W'(rdata) : COL_SUM_W'(0));

  assign col_wrap = (emit_col == ROW_W'(IMAGE_SIZE - 1));
  assign nx_col   = col_wrap ? ROW_W'(0) : emit_col + ROW_W'(1);
  assign nx_row   = col_wrap ? emit_row + ER_W'(1) : emit_row;

  assign base_slot_inc = (base_slot == SLOT_W'(WINDOW - 1)) ? SLOT_W'(0)
                                                             : base_slot + SLOT_W'(1);
  assign rd_slot_inc   = (rd_slot == SLOT_W'(WINDOW - 1)) ? SLOT_W'(0)
                                                           : rd_slot + SLOT_W'(1);

  assign cond_now  = can_emit(emit_row, emit_col, cur_r, cur_c, cur_last);
  assign cond_next = can_emit(nx_row, nx_col, cur_r, cur_c, cur_last);

  bf5_line_store #(
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (accept),
    .waddr (waddr),
    .wdata (pixels.pixel),
    .re    (fetch_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_row    <= '0;
      in_col    <= '0;
      in_slot   <= '0;
      cur_last  <= 1'b0;
      emit_row  <= '0;
      emit_col  <= '0;
      base_slot <= SLOT_W'(BASE_RESET);
      pre_cnt   <= '0;
      rd_vq     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      rd_vq <= fetch_en;
      if (results.ready && (state != ST_EMIT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cur_r    <= in_row;
            cur_c    <= in_col;
            cur_last <= in_is_last;
            if (in_is_last) begin
              in_row  <= '0;
              in_col  <= '0;
              in_slot <= '0;
            end else if (in_col == ROW_W'(IMAGE_SIZE - 1)) begin
              in_col  <= '0;
              in_row  <= in_row + ROW_W'(1);
              in_slot <= (in_slot == SLOT_W'(WINDOW - 1)) ? SLOT_W'(0)
                                                           : in_slot + SLOT_W'(1);
            end else begin
              in_col <= in_col + ROW_W'(1);
            end
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (cond_now) begin
            if (emit_col == '0) begin
              for (int i = 0; i < WINDOW; i++) begin
                taps[i] <= '0;
              end
              win_sum   <= '0;
              fetch_col <= '0;
              pre_cnt   <= K_W'(HALF_DOWN);
            end
            rd_k    <= '0;
            rd_slot <= base_slot;
            rd_off  <= CMP_W'(emit_row);
            col_acc <= '0;
            state   <= ST_COLUMN;
          end else begin
            if (cur_last) begin
              emit_row  <= '0;
              emit_col  <= '0;
              base_slot <= SLOT_W'(BASE_RESET);
            end
            state <= ST_IDLE;
          end
        end
        ST_COLUMN: begin
          col_acc <= col_total;
          rd_k    <= rd_k + K_W'(1);
          rd_off  <= rd_off + CMP_W'(1);
          rd_slot <= rd_slot_inc;
          if (rd_k == K_W'(WINDOW - 1)) begin
            state <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          taps[0] <= col_total;
          for (int i = 1; i < WINDOW; i++) begin
            taps[i] <= taps[i-1];
          end
          win_sum   <= win_sum + SUM_W'(col_total) - SUM_W'(taps[WINDOW-1]);
          fetch_col <= fetch_col + CMP_W'(1);
          if (pre_cnt != '0) begin
            pre_cnt <= pre_cnt - K_W'(1);
            rd_k    <= '0;
            rd_slot <= base_slot;
            rd_off  <= CMP_W'(emit_row);
            col_acc <= '0;
            state   <= ST_COLUMN;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= PROD_W'(win_sum) * PROD_W'(RECIP);
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            res_valid     <= 1'b1;
            res_smoothed  <= prod[PROD_W-1 -: PIXEL_W];
            res_row       <= emit_row[POS_W-1:0];
            res_col       <= emit_col[POS_W-1:0];
            res_run_last  <= !cond_next;
            res_frame_end <= !cond_next && cur_last;
            if (!cond_next && cur_last) begin
              emit_row  <= '0;
              emit_col  <= '0;
              base_slot <= SLOT_W'(BASE_RESET);
            end else begin
              emit_col <= nx_col;
              emit_row <= nx_row;
              if (col_wrap) begin
                base_slot <= base_slot_inc;
              end
            end
            if (!cond_next) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_CHECK;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign pixels.ready      = (state == ST_IDLE);
  assign results.valid     = res_valid;
  assign results.smoothed  = res_smoothed;
  assign results.out_row   = res_row;
  assign results.out_col   = res_col;
  assign results.run_last  = res_run_last;
  assign results.frame_end = res_frame_end;

  // A result is only ever built for a position inside the frame.
  a_emit_in_frame: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (emit_row < ER_W'(IMAGE_SIZE)))
    else $error("result built for a row outside the frame");

  // The column window must be fully loaded when the sum goes to the multiplier.
  a_window_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (fetch_col == CMP_W'(emit_col) + CMP_W'(HALF_DOWN + 1)))
    else $error("column window out of step with the result position");

  // A column sum is folded in only right after its line store reads.
  a_shift_after_fetch: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT) |-> ($past(state) == ST_COLUMN))
    else $error("column sum shifted in without a fetch");

endmodule : box_filter_5x5_zero_pad

`default_nettype wire

[tb/box_filter_5x5_zero_pad_test.sv]
// Testbench for box_filter_5x5_zero_pad: random frames checked against a predictor.
`timescale 1ns / 100ps

module box_filter_5x5_zero_pad_test;
  import bf5_pkg::*;

  localparam int IMAGE_SIZE = 8;
  localparam int WINDOW     = 5;
  localparam int REACH_UP   = WINDOW / 2;
  localparam int REACH_DOWN = WINDOW - 1 - REACH_UP;
  localparam int AREA       = WINDOW * WINDOW;
  localparam int MAX_WAIT   = 17;
  localparam int TAIL_WAIT  = 60;
  localparam int CYCLE_CAP  = 200000;

  typedef struct packed {
    logic [PIXEL_W-1:0] smoothed;
    logic [POS_W-1:0]   out_row;
    logic [POS_W-1:0]   out_col;
    logic               run_last;
    logic               frame_end;
  } mean_t;

  logic clk = 1'b0;
  logic rst;

  bf5_pixel_if  pixel_ch ();
  bf5_result_if result_ch ();

  box_filter_5x5_zero_pad #(
    .IMAGE_SIZE(IMAGE_SIZE),
    .WINDOW    (WINDOW)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .pixels (pixel_ch),
    .results(result_ch)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  mean_t              pending_means[$];
  logic [PIXEL_W-1:0] kept_rows[WINDOW][IMAGE_SIZE];
  int unsigned        in_row, in_col, emit_row, emit_col;
  int unsigned        error_count = 0;
  int unsigned        cycle_count = 0;
  bit                 quiet_mode;

  function automatic int unsigned draw_wait();
    if (quiet_mode || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic int unsigned clip_edge(int unsigned v);
    return (v > IMAGE_SIZE - 1) ? IMAGE_SIZE - 1 : v;
  endfunction

  function automatic logic [PIXEL_W-1:0] window_mean(int r, int c);
    int unsigned sum;
    int rr;
    int cc;
    sum = 0;
    for (int dr = -REACH_UP; dr <= REACH_DOWN; dr++) begin
      rr = r + dr;
      if (rr < 0 || rr >= IMAGE_SIZE) continue;
      for (int dc = -REACH_UP; dc <= REACH_DOWN; dc++) begin
        cc = c + dc;
        if (cc < 0 || cc >= IMAGE_SIZE) continue;
        sum += kept_rows[rr % WINDOW][cc];
      end
    end
    return PIXEL_W'(sum / AREA);
  endfunction

  // Stores one pixel and queues every mean whose window is now complete.
  task automatic predict_pixel(input logic [PIXEL_W-1:0] value);
    mean_t       batch[$];
    mean_t       m;
    bit          frame_done;
    int unsigned need_r;
    int unsigned need_c;
    frame_done = (in_row == IMAGE_SIZE - 1) && (in_col == IMAGE_SIZE - 1);
    kept_rows[in_row % WINDOW][in_col] = value;
    while (emit_row < IMAGE_SIZE) begin
      need_r = clip_edge(emit_row + REACH_DOWN);
      need_c = clip_edge(emit_col + REACH_DOWN);
      if (!(frame_done || need_r < in_row || (need_r == in_row && need_c <= in_col))) break;
      m.smoothed  = window_mean(emit_row, emit_col);
      m.out_row   = POS_W'(emit_row);
      m.out_col   = POS_W'(emit_col);
      m.run_last  = 1'b0;
      m.frame_end = 1'b0;
      batch.push_back(m);
      emit_col++;
      if (emit_col >= IMAGE_SIZE) begin
        emit_col = 0;
        emit_row++;
      end
    end
    if (batch.size() > 0) begin
      batch[batch.size() - 1].run_last  = 1'b1;
      batch[batch.size() - 1].frame_end = frame_done;
    end
    foreach (batch[i]) pending_means.push_back(batch[i]);
    if (frame_done) begin
      in_row   = 0;
      in_col   = 0;
      emit_row = 0;
      emit_col = 0;
    end else begin
      in_col++;
      if (in_col >= IMAGE_SIZE) begin
        in_col = 0;
        in_row++;
      end
    end
  endtask

  task automatic push_pixel(input logic [PIXEL_W-1:0] value);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      pixel_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_ch.valid <= 1'b1;
    pixel_ch.pixel <= value;
    do @(posedge clk); while (!pixel_ch.ready);
    predict_pixel(value);
  endtask

  task automatic wait_for_drain();
    pixel_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_means.size() != 0);
  endtask

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at cycle %0d: %s", cycle_count, msg);
  endtask

  // Output side: ready may drop for a random wait after each item.
  initial begin
    int unsigned stall;
    logic        ready_next;
    stall = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        ready_next = 1'b0;
      end else begin
        if (result_ch.valid && result_ch.ready) stall = draw_wait();
        else if (stall > 0) stall--;
        ready_next = (stall == 0);
      end
      result_ch.ready <= ready_next;
    end
  end

  always @(posedge clk) begin
    mean_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_means.size() == 0) begin
        report_error($sformatf("unexpected item mean=%0d row=%0d col=%0d",
                               result_ch.smoothed, result_ch.out_row, result_ch.out_col));
      end else begin
        want = pending_means.pop_front();
        if (result_ch.smoothed !== want.smoothed || result_ch.out_row !== want.out_row ||
            result_ch.out_col !== want.out_col || result_ch.run_last !== want.run_last ||
            result_ch.frame_end !== want.frame_end) begin
          report_error($sformatf(
            "expected mean=%0d row=%0d col=%0d run_last=%0b frame_end=%0b, got %0d %0d %0d %0b %0b",
            want.smoothed, want.out_row, want.out_col, want.run_last, want.frame_end,
            result_ch.smoothed, result_ch.out_row, result_ch.out_col,
            result_ch.run_last, result_ch.frame_end));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("box_filter_5x5_zero_pad_test: FAIL");
      $finish;
    end
  end

  function automatic logic [PIXEL_W-1:0] random_pixel(int unsigned flavor);
    case (flavor)
      0: return PIXEL_W'($urandom_range(0, PIXEL_MAX));
      1: return ($urandom_range(0, 1) == 1) ? PIXEL_W'(PIXEL_MAX) : '0;
      2: return ($urandom_range(0, 7) != 0) ? PIXEL_W'(PIXEL_MAX)
                                            : PIXEL_W'($urandom_range(0, PIXEL_MAX));
      default: return PIXEL_W'($urandom_range(0, 15));
    endcase
  endfunction

  // A full-scale row, a zero row and a row of alternating bit patterns at the top border.
  task automatic test_extreme_pixels();
    quiet_mode = 1'b0;
    for (int i = 0; i < IMAGE_SIZE; i++) push_pixel(PIXEL_W'(PIXEL_MAX));
    for (int i = 0; i < IMAGE_SIZE; i++) push_pixel('0);
    for (int i = 0; i < IMAGE_SIZE; i++) push_pixel((i % 2 == 0) ? 8'h55 : 8'hAA);
  endtask

  // Completes the first frame back to back, which exercises the end-of-frame flush.
  task automatic test_back_to_back_flush();
    quiet_mode = 1'b1;
    while (!(in_row == 0 && in_col == 0)) push_pixel(random_pixel(0));
  endtask

  task automatic test_pause_mid_frame();
    quiet_mode = 1'b0;
    for (int i = 0; i < 30; i++) push_pixel(random_pixel(0));
    wait_for_drain();
    while (!(in_row == 0 && in_col == 0)) push_pixel(random_pixel(0));
  endtask

  task automatic test_random_frames(input int unsigned frames);
    int unsigned flavor;
    for (int f = 0; f < frames; f++) begin
      flavor     = $urandom_range(0, 3);
      quiet_mode = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < IMAGE_SIZE * IMAGE_SIZE; i++) push_pixel(random_pixel(flavor));
    end
  endtask

  initial begin
    quiet_mode  = 1'b0;
    in_row      = 0;
    in_col      = 0;
    emit_row    = 0;
    emit_col    = 0;
    rst            <= 1'b1;
    pixel_ch.valid <= 1'b0;
    pixel_ch.pixel <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_extreme_pixels();
    test_back_to_back_flush();
    test_pause_mid_frame();
    test_random_frames(3);

    wait_for_drain();
    repeat (TAIL_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("box_filter_5x5_zero_pad_test: PASS");
    end else begin
      $display("box_filter_5x5_zero_pad_test: FAIL");
    end
    $finish;
  end

endmodule : box_filter_5x5_zero_pad_test

[sim.f]
hdl/bf5_pkg.sv
hdl/bf5_if.sv
hdl/bf5_line_store.sv
hdl/box_filter_5x5_zero_pad.sv
tb/box_filter_5x5_zero_pad_test.sv
